### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared assertion macros for block checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while the active-low reset is asserted
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg
// constants and types shared by the table driven prefix-code decoder
// ----------------------------------------------------------------------------
`default_nettype none

package htd_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int CODE_BITS   = 32;
    localparam int QUEUE_BITS  = CODE_BITS + 8;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int NS_W        = IDX_W + 1;
    localparam int CNT_W       = $clog2(QUEUE_BITS + 1);
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 6;
    localparam int ENTRY_W     = SYM_W + LEN_W + CODE_BITS;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SYMBOLS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CODE_LEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CODE_LEN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_VALID_BITS = 2'd3;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    typedef struct packed {
        logic push;
        logic scan_start;
        logic scan_step;
        logic emit;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic need_decode;
        logic scan_last;
        logic nsym_zero;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

### rtl/core/htd_ram.sv
// ----------------------------------------------------------------------------
// htd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module htd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/core/htd_ctrl.sv
// ----------------------------------------------------------------------------
// htd_ctrl
// sequencer: queue update, table scan per symbol, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module htd_ctrl import htd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_acc,
    input  wire logic  i_req_type,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_acc && (i_req_type == REQ_DATA)) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.need_decode) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = i_stat.nsym_zero ? ST_DRAIN : ST_SCAN;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

### rtl/core/htd_dp.sv
// ----------------------------------------------------------------------------
// htd_dp
// datapath: config registers, code table, bit queue, match search, result reg
// ----------------------------------------------------------------------------
`default_nettype none

module htd_dp import htd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    input  wire logic                  i_load,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [7:0]            i_entry_index,
    input  wire logic [7:0]            i_entry_symbol,
    input  wire logic [5:0]            i_entry_length,
    input  wire logic [31:0]           i_entry_code,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_last_byte,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output logic [7:0]                 o_symbol,
    output logic                       o_no_match,
    output logic                       o_run_end
);

    logic [8:0]            r_nsym;
    logic [5:0]            r_minl;
    logic [5:0]            r_maxl;
    logic [3:0]            r_lvb;
    logic [QUEUE_BITS-1:0] r_queue;
    logic [CNT_W-1:0]      r_count;
    logic                  r_last;
    logic [NS_W-1:0]       r_j;
    logic                  r_cmp_v;
    logic                  r_hit;
    logic [LEN_W-1:0]      r_best_len;
    logic [SYM_W-1:0]      r_best_sym;
    logic                  r_ov;

    logic                  wr_en;
    logic [ENTRY_W-1:0]    wr_data;
    logic [ENTRY_W-1:0]    rd_data;
    logic [SYM_W-1:0]      e_sym;
    logic [LEN_W-1:0]      e_len;
    logic [CODE_BITS-1:0]  e_code;
    logic [5:0]            minl_eff;
    logic [5:0]            maxl_eff;
    logic [3:0]            valid_bits;
    logic [CNT_W-1:0]      thr;
    logic [NS_W-1:0]       nsym_eff;
    logic                  len_ok;
    logic [CNT_W-1:0]      sh;
    logic [QUEUE_BITS-1:0] window;
    logic [CODE_BITS-1:0]  mask;
    logic                  match;
    logic [CNT_W-1:0]      consume;
    logic [CNT_W-1:0]      new_count;
    logic                  more;

    assign wr_en   = i_load && ({1'b0, i_entry_index} < 9'(TABLE_DEPTH));
    assign wr_data = {i_entry_symbol, i_entry_length, CODE_BITS'(i_entry_code)};

    htd_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(i_entry_index[IDX_W-1:0]),
        .i_wdata(wr_data),
        .i_raddr(r_j[IDX_W-1:0]),
        .o_rdata(rd_data)
    );

    assign e_sym  = rd_data[ENTRY_W-1 -: SYM_W];
    assign e_len  = rd_data[CODE_BITS +: LEN_W];
    assign e_code = rd_data[CODE_BITS-1:0];

    assign minl_eff   = (r_minl == 6'd0) ? 6'd1 : r_minl;
    assign maxl_eff   = (r_maxl == 6'd0) ? 6'd1 :
                        ((r_maxl > 6'(CODE_BITS)) ? 6'(CODE_BITS) : r_maxl);
    assign valid_bits = (r_lvb > 4'd8) ? 4'd8 : r_lvb;
    assign thr        = r_last ? CNT_W'(4'd8 - valid_bits) : CNT_W'(maxl_eff);
    assign nsym_eff   = (r_nsym > 9'(TABLE_DEPTH)) ? NS_W'(TABLE_DEPTH) : NS_W'(r_nsym);

    assign len_ok = (e_len >= minl_eff) && (e_len <= maxl_eff)
                    && (8'(e_len) <= 8'(r_count));
    assign sh     = r_count - CNT_W'(e_len);
    assign window = r_queue >> sh;
    assign mask   = ~({CODE_BITS{1'b1}} << e_len);
    assign match  = len_ok && (((window[CODE_BITS-1:0] ^ e_code) & mask) == '0);

    assign consume   = r_hit ? CNT_W'(r_best_len) :
                       ((8'(maxl_eff) < 8'(r_count)) ? CNT_W'(maxl_eff) : r_count);
    assign new_count = r_count - consume;
    assign more      = (new_count > thr);

    assign o_stat.need_decode = (r_count > thr);
    assign o_stat.scan_last   = (r_j == nsym_eff - NS_W'(1));
    assign o_stat.nsym_zero   = (nsym_eff == '0);
    assign o_stat.out_free    = !r_ov || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nsym <= 9'd256;
            r_minl <= 6'd1;
            r_maxl <= 6'd32;
            r_lvb  <= 4'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_SYMBOLS:     r_nsym <= i_cfg_data;
                CFG_MIN_CODE_LEN:    r_minl <= i_cfg_data[5:0];
                CFG_MAX_CODE_LEN:    r_maxl <= i_cfg_data[5:0];
                CFG_LAST_VALID_BITS: r_lvb  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue <= '0;
            r_count <= '0;
            r_last  <= 1'b0;
        end else if (i_cmd.push) begin
            r_queue <= {r_queue[QUEUE_BITS-9:0], i_data_byte};
            r_count <= r_count + CNT_W'(8);
            r_last  <= i_last_byte;
        end else if (i_cmd.emit) begin
            if (r_last && !more) begin
                r_queue <= '0;
                r_count <= '0;
            end else begin
                r_count <= new_count;
            end
        end else if (i_cmd.finish && r_last) begin
            r_queue <= '0;
            r_count <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j     <= '0;
            r_cmp_v <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_cmp_v <= i_cmd.scan_step;
            if (i_cmd.scan_start) begin
                r_j   <= '0;
                r_hit <= 1'b0;
            end else begin
                if (i_cmd.scan_step) begin
                    r_j <= r_j + NS_W'(1);
                end
                if (r_cmp_v && match && (!r_hit || (e_len < r_best_len))) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_v && match && (!r_hit || (e_len < r_best_len))) begin
            r_best_len <= e_len;
            r_best_sym <= e_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_symbol   <= r_hit ? r_best_sym : '0;
            o_no_match <= !r_hit;
            o_run_end  <= !more;
        end
    end

    assign o_out_valid = r_ov;

endmodule

`default_nettype wire

### rtl/core/huffman_table_decoder.sv
// ----------------------------------------------------------------------------
// huffman_table_decoder
// table driven prefix-code decoder with a loadable code table
// ----------------------------------------------------------------------------
// input channel (i_in_valid / o_in_stall): one transaction is either a table
// load (req_type 0) or a compressed byte (req_type 1). a load is written to
// the table as it is accepted and the channel is ready again at once.
// a data byte enters the bit queue; each symbol it yields takes one scan of
// the table ram, one entry per cycle. a byte that yields nothing goes from
// the check state straight back to idle. the next input is taken once all
// symbols of a byte are handed off.
// output channel (o_out_valid / i_out_stall): one transaction per symbol or
// no-match result; run_end marks the last one of a byte. a result sits in the
// output register while stalled, and the next scan runs meanwhile.
// config port (i_cfg_valid / o_cfg_ready): always ready, write when idle.
// reset clears the queue and config to defaults; the table is undefined until
// loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_table_decoder import htd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_req_type,
    input  wire logic [7:0]            i_entry_index,
    input  wire logic [7:0]            i_entry_symbol,
    input  wire logic [5:0]            i_entry_length,
    input  wire logic [31:0]           i_entry_code,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_last_byte,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [7:0]                 o_symbol,
    output logic                       o_no_match,
    output logic                       o_run_end,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_stat stat;
    logic busy;
    logic in_acc;

    assign in_acc      = i_in_valid && !busy;
    assign o_in_stall  = busy;
    assign o_cfg_ready = 1'b1;

    htd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_acc  (in_acc),
        .i_req_type(i_req_type),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_busy    (busy)
    );

    htd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_load        (in_acc && (i_req_type == REQ_LOAD)),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_entry_index (i_entry_index),
        .i_entry_symbol(i_entry_symbol),
        .i_entry_length(i_entry_length),
        .i_entry_code  (i_entry_code),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_symbol      (o_symbol),
        .o_no_match    (o_no_match),
        .o_run_end     (o_run_end)
    );

endmodule

`default_nettype wire

### rtl/core/htd_checker.sv
// ----------------------------------------------------------------------------
// htd_checker
// port level checks for the prefix-code decoder
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module htd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       i_req_type,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_symbol,
    input wire logic       o_no_match,
    input wire logic       o_run_end
);

    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "out valid dropped while stalled")
    `CHK_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable({o_symbol, o_no_match, o_run_end}), "stalled result changed")
    `CHK_ASSERT(a_nomatch_sym, i_clk, i_rst_n, o_out_valid && o_no_match |-> (o_symbol == 8'd0), "no-match result with nonzero symbol")
    `CHK_ASSERT(a_busy_after_data, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_req_type |=> o_in_stall, "data byte not followed by busy")

endmodule

bind huffman_table_decoder htd_checker u_htd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_req_type (i_req_type),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_symbol   (o_symbol),
    .o_no_match (o_no_match),
    .o_run_end  (o_run_end)
);

`default_nettype wire
